@@ hdl/painter_face_depth_sort_unit_macros.svh @@
// Assertion macros for the face depth sort block.
// Included by the top level only; no other dependencies.
`ifndef PAINTER_FACE_DEPTH_SORT_UNIT_MACROS_SVH
`define PAINTER_FACE_DEPTH_SORT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pfds_pkg.sv @@
// Shared types and constants for the face depth sort block.
// No dependencies.
package pfds_pkg;

  localparam int KEY_W     = 40;
  localparam int IDX_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EYE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

@@ hdl/painter_face_depth_sort_unit.sv @@
// Painter's-order face depth sort: vertex accumulation, key pipeline, key memory
// and selection scan. Depends on pfds_pkg and painter_face_depth_sort_unit_macros.svh.
//
// Usage:
//  - Vertex channel (in_valid / in_stall): one vertex per transfer, four per face,
//    taken at one per cycle while loading. final_vertex on the last vertex of the
//    last face ends loading; an incomplete trailing face is dropped, and faces
//    beyond MAX_FACES are dropped.
//  - Result channel (out_valid / out_stall): one result per stored face, farthest
//    first, equal keys in load order; draw_last marks the nearest face.
//  - Configuration: cfg_we writes eye_x/eye_y/eye_z (cfg_index 0..2) at once.
//  - Each completed face's key goes through a three-stage pipeline (difference,
//    square, sum/saturate) into the key memory. After final_vertex the input
//    stalls, the pipeline drains, then each result comes from a scan of all n
//    stored faces in the key memory, one read per cycle. The key memory has a
//    single read port.
//  - A stalled result holds in the output register; the next scan starts after it
//    transfers. Input is accepted again after the draw_last transfer.
//  - Reset (rst, synchronous) clears the eye registers, sums and face count and
//    returns to loading; the key memory is not cleared (only written entries are
//    ever read).
module painter_face_depth_sort_unit #(
  parameter int MAX_FACES      = 32,
  parameter int VERTS_PER_FACE = 4,
  parameter int COORD_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_BITS-1:0]    vertex_x,
  input  logic signed [COORD_BITS-1:0]    vertex_y,
  input  logic signed [COORD_BITS-1:0]    vertex_z,
  input  logic                            final_vertex,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pfds_pkg::IDX_W-1:0]      face_index,
  output logic [pfds_pkg::KEY_W-1:0]      depth_key,
  output logic                            draw_last,
  input  logic                            cfg_we,
  input  logic [pfds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]           cfg_data
);
  import pfds_pkg::*;

  `include "painter_face_depth_sort_unit_macros.svh"

  localparam int AW    = $clog2(MAX_FACES);
  localparam int CW    = $clog2(MAX_FACES + 1);
  localparam int VW    = $clog2(VERTS_PER_FACE);
  localparam int SUM_W = COORD_BITS + 2;
  localparam int DIF_W = COORD_BITS + 3;
  localparam int MAG_W = COORD_BITS + 2;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int TOT_W = SQ_W + 2;
  localparam logic [CW-1:0] FACES_MAX = CW'(MAX_FACES);
  localparam logic [VW-1:0] LAST_VERT = VW'(VERTS_PER_FACE - 1);

  state_t state, state_next;

  // eye registers
  logic signed [COORD_BITS-1:0] eye_x, eye_y, eye_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_x <= '0;
      eye_y <= '0;
      eye_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EYE_X: eye_x <= cfg_data;
        REG_EYE_Y: eye_y <= cfg_data;
        REG_EYE_Z: eye_z <= cfg_data;
        default:   ;
      endcase
    end
  end

  // vertex accumulation
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic signed [SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;
  logic [VW-1:0]           vertex_in_face;
  logic [CW-1:0]           faces_loaded, faces_next;
  logic                    in_xfer, face_done, face_keep;

  assign in_xfer   = in_valid && !in_stall;
  assign face_done = (vertex_in_face == LAST_VERT);
  assign face_keep = in_xfer && face_done && (faces_loaded != FACES_MAX);
  assign faces_next = faces_loaded + CW'(face_keep);

  assign sum_x_next = sum_x + {{2{vertex_x[COORD_BITS-1]}}, vertex_x};
  assign sum_y_next = sum_y + {{2{vertex_y[COORD_BITS-1]}}, vertex_y};
  assign sum_z_next = sum_z + {{2{vertex_z[COORD_BITS-1]}}, vertex_z};

  // key pipeline: difference, square, sum
  logic signed [SUM_W-1:0] eye4_x, eye4_y, eye4_z;
  logic signed [DIF_W-1:0] dif_x, dif_y, dif_z;
  logic                    p1_valid, p2_valid;
  logic [AW-1:0]           p1_addr, p2_addr;
  logic [MAG_W-1:0]        mag_x, mag_y, mag_z;
  logic [SQ_W-1:0]         sq_x, sq_y, sq_z;
  logic [TOT_W-1:0]        key_total;
  logic [TOT_W+KEY_W-1:0]  key_wide;
  logic [KEY_W-1:0]        key_sat;

  assign eye4_x = {eye_x, 2'b00};
  assign eye4_y = {eye_y, 2'b00};
  assign eye4_z = {eye_z, 2'b00};

  function automatic logic [MAG_W-1:0] magnitude(input logic signed [DIF_W-1:0] d);
    logic signed [DIF_W-1:0] neg;
    neg = -d;
    return d[DIF_W-1] ? neg[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

  assign mag_x = magnitude(dif_x);
  assign mag_y = magnitude(dif_y);
  assign mag_z = magnitude(dif_z);

  assign key_total = TOT_W'(sq_x) + TOT_W'(sq_y) + TOT_W'(sq_z);
  assign key_wide  = {{KEY_W{1'b0}}, key_total};
  assign key_sat   = (|key_wide[TOT_W+KEY_W-1:KEY_W]) ? '1 : key_wide[KEY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x          <= '0;
      sum_y          <= '0;
      sum_z          <= '0;
      vertex_in_face <= '0;
      p1_valid       <= 1'b0;
      p2_valid       <= 1'b0;
    end else begin
      p1_valid <= face_keep;
      p2_valid <= p1_valid;
      if (in_xfer) begin
        if (face_done || final_vertex) begin
          sum_x          <= '0;
          sum_y          <= '0;
          sum_z          <= '0;
          vertex_in_face <= '0;
        end else begin
          sum_x          <= sum_x_next;
          sum_y          <= sum_y_next;
          sum_z          <= sum_z_next;
          vertex_in_face <= vertex_in_face + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (face_keep) begin
      dif_x   <= {eye4_x[SUM_W-1], eye4_x} - {sum_x_next[SUM_W-1], sum_x_next};
      dif_y   <= {eye4_y[SUM_W-1], eye4_y} - {sum_y_next[SUM_W-1], sum_y_next};
      dif_z   <= {eye4_z[SUM_W-1], eye4_z} - {sum_z_next[SUM_W-1], sum_z_next};
      p1_addr <= faces_loaded[AW-1:0];
    end
    if (p1_valid) begin
      sq_x    <= mag_x * mag_x;
      sq_y    <= mag_y * mag_y;
      sq_z    <= mag_z * mag_z;
      p2_addr <= p1_addr;
    end
  end

  // key memory
  logic [KEY_W-1:0] key_mem [MAX_FACES];
  logic [KEY_W-1:0] rd_key;
  logic             mem_re, rd_valid;
  logic [AW-1:0]    rd_addr_q;
  logic [CW-1:0]    scan_cnt;

  always_ff @(posedge clk) begin
    if (p2_valid) begin
      key_mem[p2_addr] <= key_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_key    <= key_mem[scan_cnt[AW-1:0]];
      rd_addr_q <= scan_cnt[AW-1:0];
    end
  end

  // selection scan
  logic [MAX_FACES-1:0] done;
  logic [CW-1:0]        remaining;
  logic                 best_valid, best_take;
  logic [KEY_W-1:0]     best_key;
  logic [AW-1:0]        best_addr;
  logic                 out_xfer;
  logic [IDX_W+AW-1:0]  index_wide;

  assign out_xfer  = out_valid && !out_stall;
  assign best_take = rd_valid && !done[rd_addr_q] && (!best_valid || rd_key > best_key);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_xfer && final_vertex && faces_next != '0) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!p1_valid && !p2_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_cnt == faces_loaded && !rd_valid) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer) state_next = (remaining == CW'(1)) ? ST_LOAD : ST_SCAN;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_LOAD);
    out_valid = (state == ST_EMIT);
    mem_re    = (state == ST_SCAN) && (scan_cnt != faces_loaded);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      faces_loaded <= '0;
      remaining    <= '0;
      done         <= '0;
      scan_cnt     <= '0;
      rd_valid     <= 1'b0;
      best_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= mem_re;
      if (state == ST_LOAD) begin
        // drop the count at once when the stream ends; ST_DRAIN reloads it from remaining
        faces_loaded <= (in_xfer && final_vertex) ? '0 : faces_next;
        remaining    <= faces_next;
        done         <= '0;
      end
      if (state == ST_DRAIN) begin
        faces_loaded <= remaining;
      end
      if (mem_re) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (best_take) begin
        best_valid <= 1'b1;
      end
      if (state == ST_DRAIN) begin
        best_valid <= 1'b0;
        scan_cnt   <= '0;
      end
      if (out_xfer) begin
        done[best_addr] <= 1'b1;
        remaining       <= remaining - 1'b1;
        best_valid      <= 1'b0;
        scan_cnt        <= '0;
        if (remaining == CW'(1)) faces_loaded <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (best_take) begin
      best_key  <= rd_key;
      best_addr <= rd_addr_q;
    end
  end

  assign index_wide = {{IDX_W{1'b0}}, best_addr};
  assign face_index = index_wide[IDX_W-1:0];
  assign depth_key  = best_key;
  assign draw_last  = (remaining == CW'(1));

  `PFDS_ASSERT_NOW(a_scan_no_write, clk, rst, state == ST_SCAN, !p2_valid,
                   "key memory written during scan")
  `PFDS_ASSERT_NOW(a_emit_has_best, clk, rst, out_valid,
                   best_valid && !done[best_addr], "emitting without an unsent face")
  `PFDS_ASSERT_NEXT(a_last_returns, clk, rst, out_xfer && draw_last,
                    state == ST_LOAD && faces_loaded == '0, "no return to loading")
  `PFDS_ASSERT_NOW(a_remaining_bound, clk, rst, state == ST_SCAN || state == ST_EMIT,
                   remaining != '0 && remaining <= faces_loaded, "remaining count off")

endmodule
